@@ hw/rtl/thompson_nfa_builder_core_defines.svh @@
// assertion macros used by the nfa builder core
`ifndef THOMPSON_NFA_BUILDER_CORE_DEFINES_SVH
`define THOMPSON_NFA_BUILDER_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define TNB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TNB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/tnb_pkg.sv @@
// types and constants of the nfa builder
package tnb_pkg;

  localparam int MAX_TOKENS  = 64;
  localparam int STATE_BITS  = 8;
  localparam int LABEL_BITS  = 16;
  localparam int LEVEL_W     = $clog2(MAX_TOKENS + 1);
  localparam int CNT_W       = STATE_BITS + 1;
  localparam int STATE_LIMIT = 1 << STATE_BITS;
  localparam int IDX_W       = 3;

  localparam int IN_DATA_W     = ((LABEL_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = 4 * STATE_BITS + LABEL_BITS + 2;
  localparam int OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_USER_W    = 2;

  typedef logic [STATE_BITS-1:0] state_num_t;
  typedef logic [LABEL_BITS-1:0] label_t;

  typedef struct packed {
    state_num_t start;
    state_num_t fin;
  } frag_t;

  typedef enum logic [2:0] {
    TOK_SYMBOL   = 3'd0,
    TOK_CONCAT   = 3'd1,
    TOK_ALT      = 3'd2,
    TOK_STAR     = 3'd3,
    TOK_PLUS     = 3'd4,
    TOK_QUESTION = 3'd5,
    TOK_ANCHOR   = 3'd6,
    TOK_IGNORED  = 3'd7
  } tok_kind_t;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_UNDERFLOW = 2'd1,
    ERR_OVERFLOW  = 2'd2,
    ERR_EXHAUSTED = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    SH_HOLD = 2'd0,
    SH_PREV = 2'd1,
    SH_NEXT = 2'd2
  } shift_t;

  // one token's worth of work handed to the result sequencer
  typedef struct packed {
    tok_kind_t        kind;
    state_num_t       s;
    frag_t            a;
    frag_t            b;
    label_t           label;
    logic [IDX_W-1:0] n_edges;
    logic             last;
    frag_t            fin_frag;
    err_t             err;
  } job_t;

endpackage

@@ hw/rtl/thompson_nfa_builder_core.sv @@
// thompson nfa builder top: token decode, state counter and the fragment stack chain
//
//   port group | direction | tdata                 | tuser                  | tlast
//   in_        | slave     | symbol_label          | token_kind             | last_token
//   out_       | master    | src,dst,label,st,acc,err | result_kind,is_epsilon | last_of_run
//
// a token is decoded and the stack updated in the cycle it is accepted; it then gives one
// result a cycle unless out_tready stalls, none to six; plus and question with a last token give
// the most; the next token is taken as the sequencer hands over the final result of the current one
// the output register lets a token be taken while a result waits on out_tready
// synchronous active-low reset clears level, counter, error and the sequencer; no clearing pass
`include "thompson_nfa_builder_core_defines.svh"

module thompson_nfa_builder_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tnb_pkg::IN_DATA_W-1:0]  in_tdata,   // symbol_label
  input  logic [2:0]                     in_tuser,   // token_kind
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [tnb_pkg::OUT_DATA_W-1:0] out_tdata,  // source, dest, label, start, accept, error
  output logic [tnb_pkg::OUT_USER_W-1:0] out_tuser,  // result_kind, is_epsilon
  output logic                           out_tlast
);
  import tnb_pkg::*;

  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [CNT_W-1:0]   next_r, next_nxt;
  err_t               err_r, err_nxt;

  frag_t  cells [MAX_TOKENS];
  shift_t shift_top, shift_body;

  tok_kind_t        kind;
  logic             in_acc;
  logic [1:0]       pops;
  logic [2:0]       newst;
  logic             push_op, pop2_op, active;
  logic             uf, ov, ex, do_op;
  logic [CNT_W-1:0] sum;
  err_t             tok_err, err1, err_fin;
  logic [LEVEL_W-1:0] level_after;
  state_num_t       s;
  frag_t            a_frag, b_frag, new_top, fin_frag;
  logic [IDX_W-1:0] n_edges;
  job_t             job;
  logic             job_free;

  assign kind   = tok_kind_t'(in_tuser);
  assign in_acc = in_tvalid && in_tready;
  assign s      = next_r[STATE_BITS-1:0];

  always_comb begin
    pops    = 2'd0;
    newst   = 3'd0;
    push_op = 1'b0;
    pop2_op = 1'b0;
    active  = 1'b1;
    n_edges = '0;
    unique case (kind)
      TOK_SYMBOL, TOK_ANCHOR: begin
        push_op = 1'b1; newst = 3'd2; n_edges = IDX_W'(1);
      end
      TOK_CONCAT: begin
        pops = 2'd2; pop2_op = 1'b1; n_edges = IDX_W'(1);
      end
      TOK_ALT: begin
        pops = 2'd2; pop2_op = 1'b1; newst = 3'd2; n_edges = IDX_W'(4);
      end
      TOK_STAR: begin
        pops = 2'd1; newst = 3'd2; n_edges = IDX_W'(4);
      end
      TOK_PLUS: begin
        pops = 2'd1; newst = 3'd2; n_edges = IDX_W'(5);
      end
      TOK_QUESTION: begin
        pops = 2'd1; newst = 3'd4; n_edges = IDX_W'(5);
      end
      default: active = 1'b0;
    endcase
  end

  // error checks in priority order: underflow, overflow, exhaustion
  always_comb begin
    sum   = next_r + CNT_W'(newst);
    uf    = active && (level_r < LEVEL_W'(pops));
    ov    = active && !uf && push_op && (level_r >= LEVEL_W'(MAX_TOKENS));
    ex    = active && !uf && !ov && (sum > CNT_W'(STATE_LIMIT));
    do_op = active && !uf && !ov && !ex;
    if (uf) begin
      tok_err = ERR_UNDERFLOW;
    end else if (ov) begin
      tok_err = ERR_OVERFLOW;
    end else if (ex) begin
      tok_err = ERR_EXHAUSTED;
    end else begin
      tok_err = ERR_OK;
    end
    err1 = (err_r == ERR_OK) ? tok_err : err_r;
  end

  assign a_frag = pop2_op ? cells[1] : cells[0];
  assign b_frag = cells[0];

  always_comb begin
    new_top.start = s;
    new_top.fin   = s + STATE_BITS'(1);
    unique case (kind)
      TOK_CONCAT: begin
        new_top.start = a_frag.start;
        new_top.fin   = b_frag.fin;
      end
      TOK_PLUS: begin
        new_top.start = a_frag.start;
        new_top.fin   = s + STATE_BITS'(1);
      end
      TOK_QUESTION: begin
        new_top.start = s + STATE_BITS'(2);
        new_top.fin   = s + STATE_BITS'(3);
      end
      default: begin
        new_top.start = s;
        new_top.fin   = s + STATE_BITS'(1);
      end
    endcase
  end

  always_comb begin
    level_after = level_r;
    if (do_op && push_op) begin
      level_after = level_r + LEVEL_W'(1);
    end else if (do_op && pop2_op) begin
      level_after = level_r - LEVEL_W'(1);
    end
    // an empty stack finishes with start and accept zero
    if (level_after == '0) begin
      fin_frag = frag_t'('0);
    end else begin
      fin_frag = do_op ? new_top : cells[0];
    end
    // finishing on an empty stack counts as underflow
    if (in_tlast && (level_after == '0) && (err1 == ERR_OK)) begin
      err_fin = ERR_UNDERFLOW;
    end else begin
      err_fin = err1;
    end
  end

  always_comb begin
    level_nxt = level_r;
    next_nxt  = next_r;
    err_nxt   = err_r;
    if (in_acc) begin
      if (in_tlast) begin
        level_nxt = '0;
        next_nxt  = '0;
        err_nxt   = ERR_OK;
      end else begin
        level_nxt = level_after;
        next_nxt  = do_op ? sum : next_r;
        err_nxt   = err_fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      next_r  <= '0;
      err_r   <= ERR_OK;
    end else begin
      level_r <= level_nxt;
      next_r  <= next_nxt;
      err_r   <= err_nxt;
    end
  end

  // stack chain: top cell takes the new fragment, the rest shift with push or double pop
  assign shift_top  = (in_acc && do_op) ? SH_PREV : SH_HOLD;
  assign shift_body = (in_acc && do_op && push_op) ? SH_PREV :
                      (in_acc && do_op && pop2_op) ? SH_NEXT : SH_HOLD;

  generate
    for (genvar i = 0; i < MAX_TOKENS; i++) begin : g_cell
      if (i == 0) begin : g_top
        tnb_cell u_cell (
          .clk       (clk),
          .shift     (shift_top),
          .from_prev (new_top),
          .from_next (cells[1]),
          .frag      (cells[0])
        );
      end else if (i == MAX_TOKENS - 1) begin : g_bottom
        tnb_cell u_cell (
          .clk       (clk),
          .shift     (shift_body),
          .from_prev (cells[i-1]),
          .from_next (frag_t'('0)),
          .frag      (cells[i])
        );
      end else begin : g_mid
        tnb_cell u_cell (
          .clk       (clk),
          .shift     (shift_body),
          .from_prev (cells[i-1]),
          .from_next (cells[i+1]),
          .frag      (cells[i])
        );
      end
    end
  endgenerate

  always_comb begin
    job.kind     = kind;
    job.s        = s;
    job.a        = a_frag;
    job.b        = b_frag;
    job.label    = in_tdata[LABEL_BITS-1:0];
    job.n_edges  = do_op ? n_edges : '0;
    job.last     = in_tlast;
    job.fin_frag = fin_frag;
    job.err      = err_fin;
  end

  assign in_tready = job_free;

  tnb_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_load   (in_acc && (in_tlast || (do_op && (n_edges != '0)))),
    .job        (job),
    .job_free   (job_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `TNB_ASSERT_NEXT(a_clear_on_last, in_acc && in_tlast,
    level_r == '0 && next_r == '0 && err_r == ERR_OK, "state not cleared after last token")
  `TNB_ASSERT_NEXT(a_push_grows, in_acc && !in_tlast && do_op && push_op,
    level_r == $past(level_r) + LEVEL_W'(1), "push did not grow the stack")
  `TNB_ASSERT_IMPL(a_bounds, 1'b1,
    level_r <= LEVEL_W'(MAX_TOKENS) && next_r <= CNT_W'(STATE_LIMIT), "stack or counter out of range")

endmodule

@@ hw/rtl/tnb_cell.sv @@
// one entry of the fragment stack, shifting to and from its neighbours
module tnb_cell (
  input  logic           clk,
  input  tnb_pkg::shift_t shift,
  input  tnb_pkg::frag_t  from_prev,
  input  tnb_pkg::frag_t  from_next,
  output tnb_pkg::frag_t  frag
);
  import tnb_pkg::*;

  frag_t frag_r;
  frag_t frag_nxt;

  always_comb begin
    case (shift)
      SH_PREV: frag_nxt = from_prev;
      SH_NEXT: frag_nxt = from_next;
      default: frag_nxt = frag_r;
    endcase
  end

  always_ff @(posedge clk) begin
    frag_r <= frag_nxt;
  end

  assign frag = frag_r;

endmodule

@@ hw/rtl/tnb_emit.sv @@
// result sequencer: walks one token's edges and feeds the output register
module tnb_emit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               job_load,
  input  tnb_pkg::job_t                      job,
  output logic                               job_free,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tnb_pkg::OUT_DATA_W-1:0]     out_tdata,  // source, dest, label, start, accept, error
  output logic [tnb_pkg::OUT_USER_W-1:0]     out_tuser,  // result_kind, is_epsilon
  output logic                               out_tlast
);
  import tnb_pkg::*;

  job_t             job_r;
  logic             job_vld_r;
  logic [IDX_W-1:0] idx_r;
  logic             out_vld_r;
  logic [OUT_DATA_W-1:0] data_r;
  logic [OUT_USER_W-1:0] user_r;
  logic             tlast_r;

  logic [IDX_W-1:0] total;
  logic             final_res;
  logic             out_adv;
  logic             emit;
  state_num_t       s1, s2, s3;
  state_num_t       src, dst;
  logic             fin_rec;
  logic             eps;
  label_t           lbl;
  state_num_t       st, acc;

  assign total     = job_r.n_edges + IDX_W'(job_r.last);
  assign final_res = (idx_r == total - IDX_W'(1));
  assign out_adv   = !out_vld_r || out_tready;
  assign emit      = job_vld_r && out_adv;
  assign job_free  = !job_vld_r || (emit && final_res);

  assign s1 = job_r.s + STATE_BITS'(1);
  assign s2 = job_r.s + STATE_BITS'(2);
  assign s3 = job_r.s + STATE_BITS'(3);

  // edge endpoints in construction order
  always_comb begin
    src = job_r.s;
    dst = s1;
    unique case (job_r.kind)
      TOK_CONCAT: begin
        src = job_r.a.fin;
        dst = job_r.b.start;
      end
      TOK_ALT: begin
        case (idx_r)
          3'd0:    begin src = job_r.s;     dst = job_r.a.start; end
          3'd1:    begin src = job_r.s;     dst = job_r.b.start; end
          3'd2:    begin src = job_r.a.fin; dst = s1;            end
          default: begin src = job_r.b.fin; dst = s1;            end
        endcase
      end
      TOK_STAR, TOK_PLUS: begin
        case (idx_r)
          3'd0:    begin src = job_r.s;     dst = job_r.a.start; end
          3'd1:    begin src = job_r.a.fin; dst = s1;            end
          3'd2:    begin src = job_r.a.fin; dst = job_r.a.start; end
          3'd3:    begin src = job_r.s;     dst = s1;            end
          default: begin src = job_r.a.fin; dst = job_r.s;       end
        endcase
      end
      TOK_QUESTION: begin
        case (idx_r)
          3'd0:    begin src = job_r.s;     dst = s1;            end
          3'd1:    begin src = s2;          dst = job_r.s;       end
          3'd2:    begin src = s2;          dst = job_r.a.start; end
          3'd3:    begin src = s1;          dst = s3;            end
          default: begin src = job_r.a.fin; dst = s3;            end
        endcase
      end
      default: begin
        src = job_r.s;
        dst = s1;
      end
    endcase
  end

  always_comb begin
    fin_rec = (idx_r == job_r.n_edges);
    if (fin_rec) begin
      eps = 1'b0;
      lbl = '0;
      st  = job_r.fin_frag.start;
      acc = job_r.fin_frag.fin;
    end else begin
      eps = (job_r.kind != TOK_SYMBOL);
      lbl = (job_r.kind == TOK_SYMBOL) ? job_r.label : '0;
      st  = '0;
      acc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (job_load) begin
        job_vld_r <= 1'b1;
        idx_r     <= '0;
      end else if (emit) begin
        if (final_res) begin
          job_vld_r <= 1'b0;
        end else begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job_r <= job;
    end
    if (emit) begin
      data_r <= OUT_DATA_W'({job_r.err, acc, st, lbl,
                            fin_rec ? state_num_t'(0) : dst,
                            fin_rec ? state_num_t'(0) : src});
      user_r  <= {eps, fin_rec};
      tlast_r <= final_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = tlast_r;

endmodule
